>>> src/tbm_pkg.sv
package tbm_pkg;

    // Default number of blob slots in the key store.
    localparam int BLOB_SLOTS_DEF = 16;

    localparam int BLOB_ID_W = 32;
    localparam int KEY_W     = 7;
    localparam int XQ_W      = 25;
    localparam int EFF_W     = 14;
    localparam int BEND_W    = 14;
    localparam int PROD_W    = 40;
    localparam int U_W       = 21;
    localparam int RECIP_W   = 22;

    // Operation codes.
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_MOVE     = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_INDEX_W    = 2;
    localparam int         CFG_DATA_W     = 7;
    localparam logic [1:0] CFG_KEY_OFFSET = 2'd0;
    localparam logic [1:0] CFG_EFFECT_CTL = 2'd1;

    localparam logic [6:0] KEY_OFFSET_RST = 7'd0;
    localparam logic [4:0] EFFECT_CTL_RST = 5'd1;

    // MIDI status kinds.
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] ST_CTL      = 8'hB0;

    localparam logic [6:0]        KEY_MAX  = 7'h7f;
    localparam logic [6:0]        VEL_ON   = 7'h7f;
    localparam logic [6:0]        VEL_OFF  = 7'h00;
    localparam logic [BEND_W-1:0] BEND_MAX = 14'h3fff;

    // Fixed point constants: X is Q8.16, bend gain 170.65 = 17065 / 100.
    localparam logic signed [XQ_W-1:0]   XQ_HALF     = 25'sd32768;
    localparam logic signed [15:0]       BEND_GAIN   = 16'sd17065;
    localparam logic signed [XQ_W-1:0]   BEND_BIAS   = 25'sd819200;   // 8192 * 100
    localparam logic signed [XQ_W-1:0]   BEND_LIMIT  = 25'sd1638400;  // 16384 * 100
    localparam logic [RECIP_W-1:0]       RECIP_100   = 22'd2684355;   // ceil(2^28 / 100)
    localparam int                       RECIP_SHIFT = 28;

    // Slot reduction for a slot count that is not a power of two.
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = BLOB_ID_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    // Message select codes.
    localparam logic [2:0] MSG_NOTE_ON  = 3'd0;
    localparam logic [2:0] MSG_NOTE_OFF = 3'd1;
    localparam logic [2:0] MSG_BEND     = 3'd2;
    localparam logic [2:0] MSG_CTL_LSB  = 3'd3;
    localparam logic [2:0] MSG_CTL_MSB  = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] blob_id;
        logic [15:0] group_id;
        logic [15:0] position_x;
        logic [15:0] position_y;
    } t_in_word;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic       load;
        logic       mod_step;
        logic       key_rd;
        logic       diff_en;
        logic       mul_en;
        logic       sat_en;
        logic       rec_en;
        logic       msg_load;
        logic [2:0] msg_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       mod_done;
        logic       out_free;
    } t_status;

endpackage

>>> src/tbm_ctrl.sv
module tbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tbm_pkg::t_status  i_status,
    output tbm_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOD      = 4'd1;
    localparam logic [3:0] S_NOTE_ON  = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_NOTE_OFF = 4'd4;
    localparam logic [3:0] S_DIFF     = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_SAT      = 4'd7;
    localparam logic [3:0] S_REC      = 4'd8;
    localparam logic [3:0] S_BEND     = 4'd9;
    localparam logic [3:0] S_CTL_LSB  = 4'd10;
    localparam logic [3:0] S_CTL_MSB  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold off the sender while in reset and while an event is in progress.
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.msg_sel = tbm_pkg::MSG_NOTE_ON;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    case (i_status.op)
                        tbm_pkg::OP_NOTE_ON:  n_state = S_NOTE_ON;
                        tbm_pkg::OP_NOTE_OFF: n_state = S_READ;
                        tbm_pkg::OP_MOVE:     n_state = S_READ;
                        default:              n_state = S_IDLE;  // drop unused code
                    endcase
                end
            end
            S_NOTE_ON: begin
                o_cmd.msg_sel  = tbm_pkg::MSG_NOTE_ON;
                o_cmd.msg_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.key_rd = 1'b1;
                n_state = (i_status.op == tbm_pkg::OP_NOTE_OFF) ? S_NOTE_OFF : S_DIFF;
            end
            S_NOTE_OFF: begin
                o_cmd.msg_sel  = tbm_pkg::MSG_NOTE_OFF;
                o_cmd.msg_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat_en = 1'b1;
                n_state = S_REC;
            end
            S_REC: begin
                o_cmd.rec_en = 1'b1;
                n_state = S_BEND;
            end
            S_BEND: begin
                o_cmd.msg_sel  = tbm_pkg::MSG_BEND;
                o_cmd.msg_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_CTL_LSB;
                end
            end
            S_CTL_LSB: begin
                o_cmd.msg_sel  = tbm_pkg::MSG_CTL_LSB;
                o_cmd.msg_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_CTL_MSB;
                end
            end
            S_CTL_MSB: begin
                o_cmd.msg_sel  = tbm_pkg::MSG_CTL_MSB;
                o_cmd.msg_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/tbm_datapath.sv
module tbm_datapath #(
    parameter int BLOB_SLOTS = tbm_pkg::BLOB_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbm_pkg::t_in_word                  i_in_word,
    input  tbm_pkg::t_cmd                      i_cmd,
    output tbm_pkg::t_status                   o_status,
    input  logic                               i_cfg_valid,
    input  logic [tbm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tbm_pkg::t_out_word                 o_out_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall
);

    localparam int SLOT_W    = (BLOB_SLOTS > 1) ? $clog2(BLOB_SLOTS) : 1;
    localparam bit SLOT_POW2 = ((BLOB_SLOTS & (BLOB_SLOTS - 1)) == 0);

    // Channel = group mod 15; 16 is 1 mod 15, so fold the nibbles.
    function automatic logic [3:0] chan_mod15(input logic [15:0] g);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = 6'(g[3:0]) + 6'(g[7:4]) + 6'(g[11:8]) + 6'(g[15:12]);
        s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
        if (s2 >= 5'd15) begin
            s2 = s2 - 5'd15;
        end
        return s2[3:0];
    endfunction

    // Configuration registers.
    logic [6:0] r_key_offset;
    logic [4:0] r_eff_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_offset <= tbm_pkg::KEY_OFFSET_RST;
            r_eff_ctl    <= tbm_pkg::EFFECT_CTL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tbm_pkg::CFG_KEY_OFFSET: r_key_offset <= i_cfg_data;
                tbm_pkg::CFG_EFFECT_CTL: r_eff_ctl    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Event capture.
    logic [1:0]                       r_op;
    logic [3:0]                       r_ch;
    logic signed [tbm_pkg::XQ_W-1:0]  r_xq;
    logic [tbm_pkg::EFF_W-1:0]        r_eff;
    logic signed [tbm_pkg::XQ_W-1:0]  n_xq;
    logic [tbm_pkg::XQ_W-1:0]         w_px48;
    logic [29:0]                      w_eff_prod;

    assign w_px48 = {4'b0, i_in_word.position_x, 5'b0} + {5'b0, i_in_word.position_x, 4'b0};
    assign n_xq   = $signed({2'b00, r_key_offset, 16'h0000}) + $signed(w_px48)
                    - tbm_pkg::XQ_HALF;
    assign w_eff_prod = {i_in_word.position_y, 14'b0} - {14'b0, i_in_word.position_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_word.operation;
            r_ch  <= chan_mod15(i_in_word.group_id);
            r_xq  <= n_xq;
            r_eff <= w_eff_prod[29:16];
        end
    end

    // Slot selection.
    logic [SLOT_W-1:0] w_slot;
    logic              w_mod_done;

    if (BLOB_SLOTS == 1) begin : g_one
        assign w_slot     = '0;
        assign w_mod_done = 1'b1;
    end else if (SLOT_POW2) begin : g_mask
        logic [SLOT_W-1:0] r_blob_lo;
        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_blob_lo <= i_in_word.blob_id[SLOT_W-1:0];
            end
        end
        assign w_slot     = r_blob_lo;
        assign w_mod_done = 1'b1;
    end else begin : g_iter
        // Restoring remainder, MOD_BITS id bits per step from the top.
        logic [SLOT_W-1:0]             r_rem;
        logic [SLOT_W-1:0]             n_rem;
        logic [tbm_pkg::BLOB_ID_W-1:0] r_sh;
        logic [tbm_pkg::MOD_CNT_W-1:0] r_cnt;
        logic [SLOT_W:0]               w_acc;

        always_comb begin
            n_rem = r_rem;
            w_acc = '0;
            for (int b = 0; b < tbm_pkg::MOD_BITS; b++) begin
                w_acc = {n_rem, r_sh[tbm_pkg::BLOB_ID_W-1-b]};
                if (w_acc >= (SLOT_W+1)'(BLOB_SLOTS)) begin
                    w_acc = w_acc - (SLOT_W+1)'(BLOB_SLOTS);
                end
                n_rem = w_acc[SLOT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt <= '0;
            end else if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.mod_step && !w_mod_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_rem <= '0;
                r_sh  <= i_in_word.blob_id;
            end else if (i_cmd.mod_step && !w_mod_done) begin
                r_rem <= n_rem;
                r_sh  <= r_sh << tbm_pkg::MOD_BITS;
            end
        end

        assign w_slot     = r_rem;
        assign w_mod_done = (r_cnt == tbm_pkg::MOD_CNT_W'(tbm_pkg::MOD_STEPS));
    end

    // Key store: memory plus per-slot valid bits cleared at reset.
    logic [tbm_pkg::KEY_W-1:0] r_mem [BLOB_SLOTS];
    logic [BLOB_SLOTS-1:0]     r_key_vld;
    logic [tbm_pkg::KEY_W-1:0] r_mem_q;
    logic                      r_rd_vld;
    logic [tbm_pkg::KEY_W-1:0] w_key;
    logic [tbm_pkg::KEY_W-1:0] w_note_key;
    logic                      w_key_wr;

    // Floor of Q8.16 X, clamped to 0..127.
    assign w_note_key = r_xq[tbm_pkg::XQ_W-1] ? '0 :
                        r_xq[23]              ? tbm_pkg::KEY_MAX : r_xq[22:16];
    assign w_key_wr   = i_cmd.msg_load && (i_cmd.msg_sel == tbm_pkg::MSG_NOTE_ON);

    always_ff @(posedge i_clk) begin
        if (w_key_wr) begin
            r_mem[w_slot] <= w_note_key;
        end
        if (i_cmd.key_rd) begin
            r_mem_q  <= r_mem[w_slot];
            r_rd_vld <= r_key_vld[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
        end else if (w_key_wr) begin
            r_key_vld[w_slot] <= 1'b1;
        end
    end

    assign w_key = r_rd_vld ? r_mem_q : '0;

    // Pitch bend pipeline.
    logic signed [tbm_pkg::XQ_W-1:0]   r_diff;
    logic signed [tbm_pkg::PROD_W-1:0] r_prod;
    logic signed [tbm_pkg::PROD_W-1:0] n_prod;
    logic signed [23:0]                w_t;
    logic signed [tbm_pkg::XQ_W-1:0]   n_u;
    logic [tbm_pkg::U_W-1:0]           r_u;
    logic                              r_sat_lo;
    logic                              r_sat_hi;
    logic [tbm_pkg::U_W+tbm_pkg::RECIP_W-1:0] w_q_prod;
    logic [tbm_pkg::BEND_W-1:0]        r_bend;

    assign n_prod   = r_diff * tbm_pkg::BEND_GAIN;
    assign w_t      = r_prod[tbm_pkg::PROD_W-1:16];
    assign n_u      = $signed({w_t[23], w_t}) + tbm_pkg::BEND_BIAS;
    assign w_q_prod = (tbm_pkg::U_W+tbm_pkg::RECIP_W)'(r_u)
                      * (tbm_pkg::U_W+tbm_pkg::RECIP_W)'(tbm_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_diff <= r_xq - $signed({2'b00, w_key, 16'h0000});
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.sat_en) begin
            r_u      <= n_u[tbm_pkg::U_W-1:0];
            r_sat_lo <= n_u[tbm_pkg::XQ_W-1];
            r_sat_hi <= !n_u[tbm_pkg::XQ_W-1] && (n_u >= tbm_pkg::BEND_LIMIT);
        end
        if (i_cmd.rec_en) begin
            r_bend <= r_sat_lo ? '0 :
                      r_sat_hi ? tbm_pkg::BEND_MAX :
                                 w_q_prod[tbm_pkg::RECIP_SHIFT +: tbm_pkg::BEND_W];
        end
    end

    // Message assembly and output register.
    tbm_pkg::t_out_word w_msg;
    tbm_pkg::t_out_word r_out;
    logic               r_out_valid;
    logic               w_out_free;

    always_comb begin
        w_msg = '0;
        case (i_cmd.msg_sel)
            tbm_pkg::MSG_NOTE_ON: begin
                w_msg.status_byte = tbm_pkg::ST_NOTE_ON | {4'h0, r_ch};
                w_msg.data_first  = w_note_key;
                w_msg.data_second = tbm_pkg::VEL_ON;
                w_msg.last        = 1'b1;
            end
            tbm_pkg::MSG_NOTE_OFF: begin
                w_msg.status_byte = tbm_pkg::ST_NOTE_OFF | {4'h0, r_ch};
                w_msg.data_first  = w_key;
                w_msg.data_second = tbm_pkg::VEL_OFF;
                w_msg.last        = 1'b1;
            end
            tbm_pkg::MSG_BEND: begin
                w_msg.status_byte = tbm_pkg::ST_BEND | {4'h0, r_ch};
                w_msg.data_first  = r_bend[6:0];
                w_msg.data_second = r_bend[13:7];
                w_msg.last        = 1'b0;
            end
            tbm_pkg::MSG_CTL_LSB: begin
                w_msg.status_byte = tbm_pkg::ST_CTL | {4'h0, r_ch};
                w_msg.data_first  = {2'b01, r_eff_ctl};
                w_msg.data_second = r_eff[6:0];
                w_msg.last        = 1'b0;
            end
            tbm_pkg::MSG_CTL_MSB: begin
                w_msg.status_byte = tbm_pkg::ST_CTL | {4'h0, r_ch};
                w_msg.data_first  = {2'b00, r_eff_ctl};
                w_msg.data_second = r_eff[13:7];
                w_msg.last        = 1'b1;
            end
            default: begin
                w_msg = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.msg_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.msg_load) begin
            r_out <= w_msg;
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

    assign o_status.op       = r_op;
    assign o_status.mod_done = w_mod_done;
    assign o_status.out_free = w_out_free;

endmodule

>>> src/touch_blob_to_midi_messages_top.sv
// Touch-blob to MIDI converter. Each accepted input word is one blob event (note on, note
// off or move) and yields one or three 3-byte MIDI message words on the output channel,
// the final one marked by last; operation code 3 is dropped with no output. A note on
// maps X onto 48 semitones plus key_offset, stores the floored key in the blob's slot and
// sends note on at velocity 127; a note off sends the stored key; a move sends a pitch
// bend measured from the stored key, then the effect controller LSB and MSB from Y. The
// block handles one event at a time. A note off and a move read the stored key, and with
// a slot count that is not a power of two every event first runs the 4-bit-per-cycle
// slot reduction of the 32-bit blob id. A move runs the bend pipeline (key read,
// subtract, multiply by 170.65, bias and clamp, reciprocal divide by 100) and then sends
// its three message words through the single output register. A stalled output holds
// the event until each word is taken. The key store is zero after reset through
// per-slot valid bits, so no clearing pass is needed.
module touch_blob_to_midi_messages_top #(
    parameter int BLOB_SLOTS = tbm_pkg::BLOB_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // event input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tbm_pkg::t_in_word                i_in_word,
    // MIDI message output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tbm_pkg::t_out_word               o_out_word,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tbm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tbm_pkg::t_cmd    w_cmd;
    tbm_pkg::t_status w_status;

    // Configuration registers take a write on any cycle out of reset; the host keeps
    // writes to times with no event in flight.
    assign o_cfg_ready = i_rst_n;

    // Sequence the event: accept, reduce slot, read key, run bend, emit words.
    tbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Hold the event fields, key store, bend arithmetic and the output register.
    tbm_datapath #(
        .BLOB_SLOTS (BLOB_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> dv/tb_touch_blob_to_midi_messages_top.sv
`timescale 1ns / 100ps

module tb_touch_blob_to_midi_messages_top;
    import tbm_pkg::*;

    // Slot count of the instance below and fixed point figures of the event mapping.
    localparam int     BLOB_SLOTS    = BLOB_SLOTS_DEF;
    localparam longint Q16_ONE       = 65536;
    localparam longint Q16_HALF      = 32768;
    localparam longint X_SPAN        = 48;        // semitones covered by the x axis
    localparam longint BEND_MUL      = 17065;     // 170.65 scaled by 100
    localparam longint BEND_CENTER   = 8192;
    localparam longint BEND_DIV      = 6553600;   // 65536 * 100
    localparam longint EFF_SCALE     = 16383;

    // Codes the package leaves unnamed.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int SETTLE_CYCLES = 30;    // longest move plus slot reduction, with margin
    localparam int LONG_HOLD     = 300;   // receiver hold-off in the pressure phase
    localparam int PHASE_EVENTS  = 40;

    typedef enum logic {STEP_EVENT, STEP_WRITE} t_step_kind;

    typedef struct {
        t_step_kind                kind;
        t_in_word                  word;
        bit                        known;    // expected word typed in below
        t_out_word                 result;
        logic [CFG_INDEX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]     value;
    } t_step;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_in_word                i_in_word   = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_out_word               o_out_word;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    // Shadow of the block: key per blob slot and the two registers.
    logic [6:0]  key_store [BLOB_SLOTS];
    logic [6:0]  cur_key_offset;
    logic [4:0]  cur_effect_ctl;

    // MIDI words still owed by the block, oldest first.
    t_out_word   pending_msgs [$];
    t_step       steps [$];

    int gap_pct     = 0;
    int stall_pct   = 0;
    bit hold_armed  = 1'b0;
    int hold_left   = 0;
    int events_sent = 0;
    int msgs_checked = 0;
    int writes_done = 0;
    int fail_count  = 0;

    touch_blob_to_midi_messages_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Work out the MIDI words one blob event yields and update the key store.
    // Return the number of words; an unused operation yields none.
    function automatic int predict_midi(input t_in_word w, output t_out_word msgs [3]);
        int          slot;
        logic [7:0]  chan;
        longint      xq;
        longint      q;
        longint      num;
        logic [6:0]  key;
        logic [13:0] bend;
        logic [13:0] eff;
        logic [6:0]  ctl_num;
        slot = int'(w.blob_id % BLOB_SLOTS);
        chan = 8'(w.group_id % 16'd15);
        // X in Q8.16: offset plus x spread over four octaves, centered on the key
        xq = longint'(cur_key_offset) * Q16_ONE - Q16_HALF + longint'(w.position_x) * X_SPAN;
        case (w.operation)
            OP_NOTE_ON: begin
                if (xq < 0) begin
                    key = '0;
                end else begin
                    q   = xq / Q16_ONE;
                    key = (q > longint'(KEY_MAX)) ? KEY_MAX : 7'(q);
                end
                key_store[slot] = key;
                msgs[0] = t_out_word'{ST_NOTE_ON | chan, key, VEL_ON, 1'b1};
                return 1;
            end
            OP_NOTE_OFF: begin
                msgs[0] = t_out_word'{ST_NOTE_OFF | chan, key_store[slot], VEL_OFF, 1'b1};
                return 1;
            end
            OP_MOVE: begin
                // bend measured from the held key, clamped to 14 bits on both sides
                num = (xq - longint'(key_store[slot]) * Q16_ONE) * BEND_MUL
                      + BEND_CENTER * BEND_DIV;
                if (num < 0) begin
                    bend = '0;
                end else begin
                    q    = num / BEND_DIV;
                    bend = (q > longint'(BEND_MAX)) ? BEND_MAX : 14'(q);
                end
                eff     = 14'((longint'(w.position_y) * EFF_SCALE) >> 16);
                ctl_num = {2'b00, cur_effect_ctl};
                msgs[0] = t_out_word'{ST_BEND | chan, bend[6:0], bend[13:7], 1'b0};
                msgs[1] = t_out_word'{ST_CTL | chan, ctl_num | 7'h20, eff[6:0], 1'b0};
                msgs[2] = t_out_word'{ST_CTL | chan, ctl_num, eff[13:7], 1'b1};
                return 3;
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_step step_event(input logic [1:0] op, input logic [31:0] id,
                                         input logic [15:0] grp, input logic [15:0] px,
                                         input logic [15:0] py);
        t_step s;
        s        = '{kind: STEP_EVENT, default: '0};
        s.kind   = STEP_EVENT;
        s.word   = t_in_word'{op, id, grp, px, py};
        return s;
    endfunction

    function automatic t_step step_known(input logic [1:0] op, input logic [31:0] id,
                                         input logic [15:0] grp, input logic [15:0] px,
                                         input t_out_word res);
        t_step s;
        s        = step_event(op, id, grp, px, 16'h0000);
        s.known  = 1'b1;
        s.result = res;
        return s;
    endfunction

    function automatic t_step step_write(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        t_step s;
        s       = '{kind: STEP_WRITE, default: '0};
        s.kind  = STEP_WRITE;
        s.index = idx;
        s.value = val;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Offer one event word, hold it until taken, then queue what it should yield.
    // Valid stays high afterwards so the next word can follow with no bubble.
    task automatic send_event(input t_in_word w, input bit known, input t_out_word res);
        t_out_word msgs [3];
        int        n;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        n = predict_midi(w, msgs);
        if (known) begin
            pending_msgs.push_back(res);
        end else begin
            for (int i = 0; i < n; i++) pending_msgs.push_back(msgs[i]);
        end
        if (w.operation != OP_UNUSED) events_sent++;
    endtask

    // Write one register once the block has gone quiet.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        // let a dropped word or a late pipeline stage finish before touching registers
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_OFFSET: cur_key_offset = val;
            CFG_EFFECT_CTL: cur_effect_ctl = val[4:0];
            default: ;
        endcase
        writes_done++;
    endtask

    // One finger: note on, up to four moves, note off on the same blob and group.
    task automatic play_gesture();
        t_in_word    w;
        logic [15:0] x_on;
        w.blob_id    = $urandom();
        w.group_id   = 16'($urandom_range(0, 65535));
        x_on         = 16'($urandom_range(0, 65535));
        w.operation  = OP_NOTE_ON;
        w.position_x = x_on;
        w.position_y = 16'($urandom_range(0, 65535));
        send_event(w, 1'b0, '0);
        repeat ($urandom_range(0, 4)) begin
            w.operation  = OP_MOVE;
            // half the time slide near the struck key, else jump anywhere
            w.position_x = $urandom_range(1) ? x_on + 16'($urandom_range(0, 4095)) - 16'd2048
                                             : 16'($urandom_range(0, 65535));
            w.position_y = 16'($urandom_range(0, 65535));
            send_event(w, 1'b0, '0);
        end
        w.operation = OP_NOTE_OFF;
        send_event(w, 1'b0, '0);
    endtask

    // Random phase: set both registers, pick the idle mix, then play gestures
    // interleaved with stray words until enough real events went in.
    task automatic run_phase(input int idle_in, input int idle_out, input bit squeeze,
                             input logic [6:0] offset, input logic [4:0] ctl);
        t_in_word w;
        int       target;
        write_reg(CFG_KEY_OFFSET, offset);
        write_reg(CFG_EFFECT_CTL, {2'b00, ctl});
        gap_pct   = idle_in;
        stall_pct = idle_out;
        if (squeeze) hold_armed = 1'b1;
        target = events_sent + PHASE_EVENTS;
        while (events_sent < target) begin
            if ($urandom_range(99) < 20) begin
                w.operation  = 2'($urandom_range(0, 3));
                w.blob_id    = $urandom();
                w.group_id   = 16'($urandom_range(0, 65535));
                w.position_x = 16'($urandom_range(0, 65535));
                w.position_y = 16'($urandom_range(0, 65535));
                send_event(w, 1'b0, '0);
            end else begin
                play_gesture();
            end
        end
    endtask

    // Receiver: check every word taken, then pick the stall for the next edge.
    // A long hold-off, when armed, lets the block back up into its input.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_msgs.size() == 0) begin
                $error("MIDI word 0x%0h arrived with nothing expected", o_out_word);
                fail_count++;
            end else begin
                want = pending_msgs.pop_front();
                check_field("status_byte", want.status_byte, o_out_word.status_byte);
                check_field("data_first", {1'b0, want.data_first},
                            {1'b0, o_out_word.data_first});
                check_field("data_second", {1'b0, want.data_second},
                            {1'b0, o_out_word.data_second});
                check_field("last", {7'd0, want.last}, {7'd0, o_out_word.last});
                msgs_checked++;
            end
        end
        if (hold_armed) begin
            hold_left  = LONG_HOLD;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hard stop for a hung block.
    initial begin
        #800000;
        $display("[touch_blob_to_midi_messages_top] ERROR");
        $finish;
    end

    initial begin
        foreach (key_store[i]) key_store[i] = '0;
        cur_key_offset = KEY_OFFSET_RST;
        cur_effect_ctl = EFFECT_CTL_RST;

        // Directed part, first at reset settings.
        // Note off on a slot never struck: key store reads zero.
        steps.push_back(step_known(OP_NOTE_OFF, 32'd0, 16'd0, 16'h0000,
                                   t_out_word'{ST_NOTE_OFF, 7'd0, VEL_OFF, 1'b1}));
        steps.push_back(step_event(OP_MOVE, 32'd5, 16'd1, 16'h0000, 16'h0000));
        // Leftmost x lands below key zero and clamps; channel 14 is the top one.
        steps.push_back(step_known(OP_NOTE_ON, 32'd0, 16'd14, 16'h0000,
                                   t_out_word'{ST_NOTE_ON | 8'd14, 7'd0, VEL_ON, 1'b1}));
        // All-ones fields: slot 15, group 65535 folds to channel 0, key 47.
        steps.push_back(step_known(OP_NOTE_ON, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                   t_out_word'{ST_NOTE_ON, 7'd47, VEL_ON, 1'b1}));
        steps.push_back(step_event(OP_MOVE, 32'hFFFF_FFFF, 16'hFFFE, 16'h0000, 16'hFFFF));
        steps.push_back(step_known(OP_NOTE_OFF, 32'hFFFF_FFFF, 16'd7, 16'h0000,
                                   t_out_word'{ST_NOTE_OFF | 8'd7, 7'd47, VEL_OFF, 1'b1}));
        // Unused operation: dropped, slot 1 untouched.
        steps.push_back(step_event(OP_UNUSED, 32'd1, 16'd3, 16'h1234, 16'h4321));
        steps.push_back(step_event(OP_NOTE_OFF, 32'd1, 16'd3, 16'h0000, 16'h0000));
        // Largest offset: the key clamps at the top, a keyless slot bends to the ceiling.
        steps.push_back(step_write(CFG_KEY_OFFSET, KEY_MAX));
        steps.push_back(step_known(OP_NOTE_ON, 32'd2, 16'd5, 16'hFFFF,
                                   t_out_word'{ST_NOTE_ON | 8'd5, KEY_MAX, VEL_ON, 1'b1}));
        steps.push_back(step_event(OP_MOVE, 32'd2, 16'd5, 16'h0000, 16'h0000));
        steps.push_back(step_event(OP_MOVE, 32'd3, 16'd5, 16'hFFFF, 16'h8000));
        // Back to offset zero under a held top key: bend clamps at the floor.
        steps.push_back(step_write(CFG_KEY_OFFSET, 7'd0));
        steps.push_back(step_event(OP_MOVE, 32'd2, 16'd5, 16'h0000, 16'hFFFF));
        // Effect controller at both ends.
        steps.push_back(step_write(CFG_EFFECT_CTL, 7'd31));
        steps.push_back(step_event(OP_MOVE, 32'd4, 16'd9, 16'h8000, 16'h8000));
        steps.push_back(step_write(CFG_EFFECT_CTL, 7'd0));
        steps.push_back(step_event(OP_MOVE, 32'd4, 16'd9, 16'hAAAA, 16'h5555));
        // Writes to indexes with no register behind them change nothing.
        steps.push_back(step_write(CFG_SPARE_2, 7'h7F));
        steps.push_back(step_write(CFG_SPARE_3, 7'h7F));
        steps.push_back(step_event(OP_NOTE_ON, 32'd20, 16'd12, 16'h8000, 16'h0000));
        steps.push_back(step_event(OP_MOVE, 32'd20, 16'd12, 16'h8155, 16'h0001));
        steps.push_back(step_event(OP_NOTE_OFF, 32'd20, 16'd12, 16'h0000, 16'h0000));
        steps.push_back(step_event(OP_NOTE_ON, 32'd6, 16'd30, 16'hFFFF, 16'hFFFF));

        // Hold reset, then release it at an edge.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table with no idling on either side.
        foreach (steps[i]) begin
            if (steps[i].kind == STEP_WRITE) begin
                write_reg(steps[i].index, steps[i].value);
            end else begin
                send_event(steps[i].word, steps[i].known, steps[i].result);
            end
        end

        // Random phases: no idling, idle sender, stalling receiver, both,
        // then a long receiver hold-off against a sender that never pauses.
        run_phase(0, 0, 1'b0, KEY_MAX, 5'd31);
        run_phase(55, 0, 1'b0, 7'd0, 5'd0);
        run_phase(0, 55, 1'b0, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
        run_phase(22, 22, 1'b0, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
        run_phase(0, 0, 1'b1, 7'd64, EFFECT_CTL_RST);

        // Drain: wait out every owed word, then give stray outputs time to show.
        i_in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d blob events and %0d register writes; %0d MIDI words checked",
                 events_sent, writes_done, msgs_checked);
        $display("across idle/stall mixes, a long output hold-off and all key/bend clamps.");
        if (fail_count == 0) begin
            $display("[touch_blob_to_midi_messages_top] OK");
        end else begin
            $display("[touch_blob_to_midi_messages_top] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/tbm_pkg.sv
src/tbm_ctrl.sv
src/tbm_datapath.sv
src/touch_blob_to_midi_messages_top.sv
dv/tb_touch_blob_to_midi_messages_top.sv
